>>> sv/rrrl_pkg.sv
// ----------------------------------------------------------------------------
// rrrl_pkg: shared types for the round-robin ready list
// Command codes, controller states and the command/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package rrrl_pkg;

	// transaction command codes
	typedef enum logic [1:0] {
		CMD_WAKE  = 2'd0,
		CMD_SLEEP = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_KICK  = 2'd3
	} cmd_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_WAKE_SELF,
		ST_WAKE_TAIL,
		ST_SLEEP_UNLINK,
		ST_SUCC,
		ST_ENTER,
		ST_ENTER_WR,
		ST_RESULT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic wake_self;
		logic wake_tail;
		logic sleep_unlink;
		logic nxt_from_head;
		logic nxt_from_succ;
		logic go_idle;
		logic enter;
		logic load_out;
	} dp_ctrl_t;

	// status from datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic slot_ok;
		logic slot_awake;
		logic cur_valid;
		logic head_valid;
		logic slot_is_cur;
		logic nxt_valid;
		logic out_free;
	} dp_sts_t;

endpackage

>>> sv/rrrl_dp.sv
// ----------------------------------------------------------------------------
// rrrl_dp: ready list datapath
// Link memories, slice counter memory, head/tail/current registers and the
// output register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module rrrl_dp #(
	parameter int SLOT_COUNT = 16,
	parameter int SLICE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         command,
	input  logic [3:0]         slot,
	input  rrrl_pkg::dp_ctrl_t ctrl,
	output rrrl_pkg::dp_sts_t  sts,
	input  logic               out_stall,
	output logic               out_valid,
	output logic               idle,
	output logic [3:0]         running_slot,
	output logic [31:0]        slice_count,
	output logic               changed
);

	localparam int IDX_W  = $clog2(SLOT_COUNT);
	localparam int LINK_W = $clog2(SLOT_COUNT + 1);
	localparam int SW_W   = LINK_W + 4;
	localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOT_COUNT);

	// captured transaction and list state
	rrrl_pkg::cmd_t          cmd_q;
	logic [3:0]              slot_q;
	logic [LINK_W-1:0]       before_q;
	logic                    list_mod_q;
	logic [LINK_W-1:0]       head_q;
	logic [LINK_W-1:0]       tail_q;
	logic [LINK_W-1:0]       cur_q;
	logic [LINK_W-1:0]       nxt_q;
	logic [SLICE_BITS-1:0]   cur_slice_q;
	logic [SLOT_COUNT-1:0]   awake_q;
	logic [SLOT_COUNT-1:0]   slc_vld_q;

	// memories and registered read data
	logic [LINK_W-1:0]     next_mem [SLOT_COUNT];
	logic [LINK_W-1:0]     prev_mem [SLOT_COUNT];
	logic [SLICE_BITS-1:0] slc_mem  [SLOT_COUNT];
	logic [LINK_W-1:0]     next_rd_q;
	logic [LINK_W-1:0]     prev_rd_q;
	logic [SLICE_BITS-1:0] slc_rd_q;

	// output register
	logic        out_vld_q;
	logic        idle_q;
	logic [3:0]  running_q;
	logic [31:0] slice_q;
	logic        changed_q;

	// slot index decode
	logic [SW_W-1:0]   slot_wide;
	logic              slot_ok;
	logic [IDX_W-1:0]  slot_idx;
	logic [LINK_W-1:0] slot_link;
	logic [IDX_W-1:0]  cur_idx;
	logic [IDX_W-1:0]  tail_idx;
	logic [IDX_W-1:0]  nxt_idx;
	logic [IDX_W-1:0]  nrd_idx;

	assign slot_wide = {{LINK_W{1'b0}}, slot_q};
	assign slot_ok   = slot_wide < SW_W'(SLOT_COUNT);
	assign slot_idx  = slot_wide[IDX_W-1:0];
	assign slot_link = slot_wide[LINK_W-1:0];
	assign cur_idx   = cur_q[IDX_W-1:0];
	assign tail_idx  = tail_q[IDX_W-1:0];
	assign nxt_idx   = nxt_q[IDX_W-1:0];
	assign nrd_idx   = (cmd_q == rrrl_pkg::CMD_SLEEP) ? slot_idx : cur_idx;

	// unlink and successor selection
	logic              n_vld;
	logic              p_vld;
	logic [LINK_W-1:0] head_new;
	logic [LINK_W-1:0] sleep_succ;
	logic [LINK_W-1:0] adv_succ;

	assign n_vld      = next_rd_q < NIL;
	assign p_vld      = prev_rd_q < NIL;
	assign head_new   = p_vld ? head_q : next_rd_q;
	assign sleep_succ = n_vld ? next_rd_q : head_new;
	assign adv_succ   = n_vld ? next_rd_q : head_q;

	// slice counter increment, unwritten entries read as zero
	logic [SLICE_BITS-1:0] slc_base;
	logic [SLICE_BITS-1:0] slc_new;

	assign slc_base = slc_vld_q[nxt_idx] ? slc_rd_q : '0;
	assign slc_new  = slc_base + SLICE_BITS'(1);

	// memory write ports
	logic              next_we;
	logic [IDX_W-1:0]  next_wa;
	logic [LINK_W-1:0] next_wd;
	logic              prev_we;
	logic [IDX_W-1:0]  prev_wa;
	logic [LINK_W-1:0] prev_wd;

	always_comb begin
		next_we = 1'b0;
		next_wa = slot_idx;
		next_wd = NIL;
		prev_we = 1'b0;
		prev_wa = slot_idx;
		prev_wd = tail_q;
		if (ctrl.wake_self) begin
			next_we = 1'b1;
			prev_we = 1'b1;
		end else if (ctrl.wake_tail) begin
			next_we = tail_q < NIL;
			next_wa = tail_idx;
			next_wd = slot_link;
		end else if (ctrl.sleep_unlink) begin
			next_we = p_vld;
			next_wa = prev_rd_q[IDX_W-1:0];
			next_wd = next_rd_q;
			prev_we = n_vld;
			prev_wa = next_rd_q[IDX_W-1:0];
			prev_wd = prev_rd_q;
		end
	end

	// memories, registered reads
	always_ff @(posedge clk) begin
		next_rd_q <= next_mem[nrd_idx];
		prev_rd_q <= prev_mem[slot_idx];
		slc_rd_q  <= slc_mem[nxt_idx];
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (ctrl.enter) begin
			slc_mem[nxt_idx] <= slc_new;
		end
	end

	// list and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= rrrl_pkg::CMD_WAKE;
			slot_q      <= '0;
			before_q    <= NIL;
			list_mod_q  <= 1'b0;
			head_q      <= NIL;
			tail_q      <= NIL;
			cur_q       <= NIL;
			nxt_q       <= NIL;
			cur_slice_q <= '0;
			awake_q     <= '0;
			slc_vld_q   <= '0;
		end else begin
			if (ctrl.capture) begin
				cmd_q      <= rrrl_pkg::cmd_t'(command);
				slot_q     <= slot;
				before_q   <= cur_q;
				list_mod_q <= 1'b0;
			end
			if (ctrl.wake_self) begin
				awake_q[slot_idx] <= 1'b1;
			end
			if (ctrl.wake_tail) begin
				if (tail_q >= NIL) begin
					head_q <= slot_link;
				end
				tail_q     <= slot_link;
				list_mod_q <= 1'b1;
			end
			if (ctrl.sleep_unlink) begin
				awake_q[slot_idx] <= 1'b0;
				if (!n_vld) begin
					tail_q <= prev_rd_q;
				end
				if (!p_vld) begin
					head_q <= next_rd_q;
				end
				list_mod_q <= 1'b1;
				nxt_q      <= sleep_succ;
			end
			if (ctrl.nxt_from_head) begin
				nxt_q <= head_q;
			end
			if (ctrl.nxt_from_succ) begin
				nxt_q <= adv_succ;
			end
			if (ctrl.go_idle) begin
				cur_q       <= NIL;
				cur_slice_q <= '0;
			end
			if (ctrl.enter) begin
				cur_q              <= nxt_q;
				cur_slice_q        <= slc_new;
				slc_vld_q[nxt_idx] <= 1'b1;
			end
		end
	end

	// result fields from running state
	logic [SW_W-1:0]         cur_wide;
	logic [SLICE_BITS+31:0]  slice_wide;
	logic                    cur_vld;

	assign cur_vld    = cur_q < NIL;
	assign cur_wide   = {4'b0000, cur_q};
	assign slice_wide = {32'd0, cur_slice_q};

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			idle_q    <= !cur_vld;
			running_q <= cur_vld ? cur_wide[3:0] : 4'd0;
			slice_q   <= cur_vld ? slice_wide[31:0] : 32'd0;
			changed_q <= list_mod_q || (cur_q != before_q);
		end
	end

	assign out_valid    = out_vld_q;
	assign idle         = idle_q;
	assign running_slot = running_q;
	assign slice_count  = slice_q;
	assign changed      = changed_q;

	// status to controller
	assign sts.cmd         = cmd_q;
	assign sts.slot_ok     = slot_ok;
	assign sts.slot_awake  = slot_ok && awake_q[slot_idx];
	assign sts.cur_valid   = cur_vld;
	assign sts.head_valid  = head_q < NIL;
	assign sts.slot_is_cur = slot_link == cur_q;
	assign sts.nxt_valid   = nxt_q < NIL;
	assign sts.out_free    = !out_vld_q || !out_stall;

	// checks
	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q < NIL) == (tail_q < NIL))
		else $error("head and tail disagree on empty list");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |-> (!out_vld_q || !out_stall))
		else $error("result loaded over a pending transaction");
	a_enter_cur: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.enter |=> cur_q < NIL)
		else $error("entered slot is not a valid slot");

endmodule

>>> sv/rrrl_ctrl.sv
// ----------------------------------------------------------------------------
// rrrl_ctrl: ready list controller
// Sequences wake, sleep, tick and kick transactions over the datapath and
// hands each result to the output register.
// ----------------------------------------------------------------------------
module rrrl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rrrl_pkg::dp_sts_t  sts,
	output rrrl_pkg::dp_ctrl_t ctrl
);

	rrrl_pkg::state_t state_q;
	rrrl_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrrl_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rrrl_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = rrrl_pkg::ST_DISPATCH;
				end
			end
			rrrl_pkg::ST_DISPATCH: begin
				unique case (sts.cmd)
					rrrl_pkg::CMD_WAKE: begin
						state_nxt = (sts.slot_ok && !sts.slot_awake) ?
							rrrl_pkg::ST_WAKE_SELF : rrrl_pkg::ST_RESULT;
					end
					rrrl_pkg::CMD_SLEEP: begin
						state_nxt = (sts.slot_ok && sts.slot_awake) ?
							rrrl_pkg::ST_SLEEP_UNLINK : rrrl_pkg::ST_RESULT;
					end
					rrrl_pkg::CMD_TICK: begin
						state_nxt = sts.cur_valid ? rrrl_pkg::ST_SUCC : rrrl_pkg::ST_ENTER;
					end
					default: begin
						state_nxt = (!sts.cur_valid && sts.head_valid) ?
							rrrl_pkg::ST_ENTER : rrrl_pkg::ST_RESULT;
					end
				endcase
			end
			rrrl_pkg::ST_WAKE_SELF:    state_nxt = rrrl_pkg::ST_WAKE_TAIL;
			rrrl_pkg::ST_WAKE_TAIL:    state_nxt = rrrl_pkg::ST_RESULT;
			rrrl_pkg::ST_SLEEP_UNLINK: begin
				state_nxt = sts.slot_is_cur ? rrrl_pkg::ST_ENTER : rrrl_pkg::ST_RESULT;
			end
			rrrl_pkg::ST_SUCC:         state_nxt = rrrl_pkg::ST_ENTER;
			rrrl_pkg::ST_ENTER: begin
				state_nxt = sts.nxt_valid ? rrrl_pkg::ST_ENTER_WR : rrrl_pkg::ST_RESULT;
			end
			rrrl_pkg::ST_ENTER_WR:     state_nxt = rrrl_pkg::ST_RESULT;
			rrrl_pkg::ST_RESULT: begin
				if (sts.out_free) begin
					state_nxt = rrrl_pkg::ST_IDLE;
				end
			end
			default:                   state_nxt = rrrl_pkg::ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			rrrl_pkg::ST_IDLE:         ctrl.capture = in_valid;
			rrrl_pkg::ST_DISPATCH: begin
				ctrl.nxt_from_head = ((sts.cmd == rrrl_pkg::CMD_TICK) && !sts.cur_valid) ||
					((sts.cmd == rrrl_pkg::CMD_KICK) && !sts.cur_valid && sts.head_valid);
			end
			rrrl_pkg::ST_WAKE_SELF:    ctrl.wake_self = 1'b1;
			rrrl_pkg::ST_WAKE_TAIL:    ctrl.wake_tail = 1'b1;
			rrrl_pkg::ST_SLEEP_UNLINK: ctrl.sleep_unlink = 1'b1;
			rrrl_pkg::ST_SUCC:         ctrl.nxt_from_succ = 1'b1;
			rrrl_pkg::ST_ENTER:        ctrl.go_idle = !sts.nxt_valid;
			rrrl_pkg::ST_ENTER_WR:     ctrl.enter = 1'b1;
			rrrl_pkg::ST_RESULT:       ctrl.load_out = sts.out_free;
			default:                   ctrl = '0;
		endcase
	end

	assign in_stall = state_q != rrrl_pkg::ST_IDLE;

	// checks
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == rrrl_pkg::ST_DISPATCH)
		else $error("accepted transaction not dispatched");
	a_unlink_awake: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rrrl_pkg::ST_SLEEP_UNLINK |-> sts.slot_awake)
		else $error("unlinking a slot that is not awake");
	a_enter_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rrrl_pkg::ST_ENTER_WR |-> sts.nxt_valid)
		else $error("entering a null slot");

endmodule

>>> sv/round_robin_ready_list.sv
// Each accepted transaction runs through dispatch, the states of its command and
// a result state, which loads the output register once the output is free.
// A new transaction is accepted only after that load; the controller walks the
// link and slice counter memories (registered read, then write back).
// Reset: asynchronous, clears list, running slot and per-slot counter valid bits
// at once; link memories are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
// round_robin_ready_list: round-robin ready list scheduler
// Awake slots kept as a doubly linked list in wake order; wake and sleep edit the
// list, and sleep, tick and kick move the running slot and count its time slices.
// ----------------------------------------------------------------------------
module round_robin_ready_list #(
	parameter int SLOT_COUNT = 16,
	parameter int SLICE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [3:0]  slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        idle,
	output logic [3:0]  running_slot,
	output logic [31:0] slice_count,
	output logic        changed
);

	rrrl_pkg::dp_ctrl_t ctrl;
	rrrl_pkg::dp_sts_t  sts;

	// controller
	rrrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctrl     (ctrl)
	);

	// datapath
	rrrl_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.SLICE_BITS (SLICE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (command),
		.slot         (slot),
		.ctrl         (ctrl),
		.sts          (sts),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.idle         (idle),
		.running_slot (running_slot),
		.slice_count  (slice_count),
		.changed      (changed)
	);

endmodule
